@@ hdl/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg
// Types, widths and latency shared by the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;

	localparam int EDGE_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int SQR_W   = 2 * MAG_W;
	localparam int SUM_W   = SQR_W + 2;
	localparam int ROOT_W  = NORMAL_FRAC_BITS + 2;
	localparam int REM_W   = SQR_W + 2 * NORMAL_FRAC_BITS + 2;
	localparam int TS_W    = SUM_W + ROOT_W;
	localparam int CMP_W   = SUM_W + 2 * ROOT_W + 1;
	localparam int IDX_W   = $clog2(ROOT_W);
	localparam int OUT_W   = NORMAL_FRAC_BITS + 2;
	localparam int LATENCY = ROOT_W + 6;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_a_x;
		logic signed [COORD_BITS-1:0] vertex_a_y;
		logic signed [COORD_BITS-1:0] vertex_a_z;
		logic signed [COORD_BITS-1:0] vertex_b_x;
		logic signed [COORD_BITS-1:0] vertex_b_y;
		logic signed [COORD_BITS-1:0] vertex_b_z;
		logic signed [COORD_BITS-1:0] vertex_c_x;
		logic signed [COORD_BITS-1:0] vertex_c_y;
		logic signed [COORD_BITS-1:0] vertex_c_z;
	} tfn_req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_x;
		logic signed [OUT_W-1:0] normal_y;
		logic signed [OUT_W-1:0] normal_z;
		logic                    degenerate;
	} tfn_rsp_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [TS_W-1:0]   ts;
		logic [ROOT_W-1:0] root;
		logic              neg;
	} tfn_lane_t;

	typedef struct packed {
		logic                valid;
		logic                deg;
		logic [SUM_W-1:0]    sumsq;
		tfn_lane_t [2:0]     lane;
	} tfn_cell_t;

endpackage

@@ hdl/tfn_front.sv @@
// ----------------------------------------------------------------------------
// tfn_front
// Edges, cross product, squares and sum of squares; seeds the root chain.
// ----------------------------------------------------------------------------
module tfn_front import tfn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  tfn_req_t  req,
	output tfn_cell_t seed
);

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	tfn_req_t                  req_s1;
	logic signed [PROD_W-1:0]  prod_s2 [6];
	logic [MAG_W-1:0]          mag_s3 [3];
	logic [2:0]                neg_s3, neg_s4;
	logic                      deg_s3, deg_s4;
	logic [SQR_W-1:0]          sq_s4 [3];

	logic signed [EDGE_W-1:0]  ux, uy, uz, vx, vy, vz;
	logic signed [CROSS_W-1:0] n [3];

	always_comb begin
		ux = $signed({req_s1.vertex_a_x[COORD_BITS-1], req_s1.vertex_a_x})
			- $signed({req_s1.vertex_b_x[COORD_BITS-1], req_s1.vertex_b_x});
		uy = $signed({req_s1.vertex_a_y[COORD_BITS-1], req_s1.vertex_a_y})
			- $signed({req_s1.vertex_b_y[COORD_BITS-1], req_s1.vertex_b_y});
		uz = $signed({req_s1.vertex_a_z[COORD_BITS-1], req_s1.vertex_a_z})
			- $signed({req_s1.vertex_b_z[COORD_BITS-1], req_s1.vertex_b_z});
		vx = $signed({req_s1.vertex_a_x[COORD_BITS-1], req_s1.vertex_a_x})
			- $signed({req_s1.vertex_c_x[COORD_BITS-1], req_s1.vertex_c_x});
		vy = $signed({req_s1.vertex_a_y[COORD_BITS-1], req_s1.vertex_a_y})
			- $signed({req_s1.vertex_c_y[COORD_BITS-1], req_s1.vertex_c_y});
		vz = $signed({req_s1.vertex_a_z[COORD_BITS-1], req_s1.vertex_a_z})
			- $signed({req_s1.vertex_c_z[COORD_BITS-1], req_s1.vertex_c_z});
		n[0] = CROSS_W'(prod_s2[0]) - CROSS_W'(prod_s2[1]);
		n[1] = CROSS_W'(prod_s2[2]) - CROSS_W'(prod_s2[3]);
		n[2] = CROSS_W'(prod_s2[4]) - CROSS_W'(prod_s2[5]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			seed     <= '0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			seed.valid <= valid_s4;
			seed.deg   <= deg_s4;
			seed.sumsq <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			for (int i = 0; i < 3; i++) begin
				seed.lane[i].rem  <= REM_W'(sq_s4[i]) << (2 * NORMAL_FRAC_BITS + 2);
				seed.lane[i].ts   <= '0;
				seed.lane[i].root <= '0;
				seed.lane[i].neg  <= neg_s4[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			req_s1 <= req;
		prod_s2[0] <= uy * vz;
		prod_s2[1] <= vy * uz;
		prod_s2[2] <= vx * uz;
		prod_s2[3] <= ux * vz;
		prod_s2[4] <= ux * vy;
		prod_s2[5] <= vx * uy;
		for (int i = 0; i < 3; i++) begin
			mag_s3[i] <= MAG_W'(n[i][CROSS_W-1] ? -n[i] : n[i]);
			neg_s3[i] <= n[i][CROSS_W-1];
			sq_s4[i]  <= SQR_W'(mag_s3[i]) * SQR_W'(mag_s3[i]);
		end
		deg_s3 <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
		neg_s4 <= neg_s3;
		deg_s4 <= deg_s3;
	end

endmodule

@@ hdl/tfn_cell.sv @@
// ----------------------------------------------------------------------------
// tfn_cell
// One root bit for all three lanes: largest T with T^2 * S <= m^2 * 4^(F+1).
// ----------------------------------------------------------------------------
module tfn_cell import tfn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] bit_idx,
	input  tfn_cell_t        d,
	output tfn_cell_t        q
);

	tfn_cell_t        nxt;
	logic [IDX_W:0]   sh1, sh2;
	logic [CMP_W-1:0] term [3];
	logic [2:0]       fit;

	always_comb begin
		nxt = d;
		sh1 = {1'b0, bit_idx} + 1'b1;
		sh2 = {bit_idx, 1'b0};
		for (int i = 0; i < 3; i++) begin
			// (T + 2^k)^2 S - T^2 S = 2^(k+1) T S + 4^k S
			term[i] = (CMP_W'(d.lane[i].ts) << sh1) + (CMP_W'(d.sumsq) << sh2);
			fit[i]  = term[i] <= CMP_W'(d.lane[i].rem);
			if (fit[i]) begin
				nxt.lane[i].rem  = REM_W'(CMP_W'(d.lane[i].rem) - term[i]);
				nxt.lane[i].ts   = d.lane[i].ts + (TS_W'(d.sumsq) << bit_idx);
				nxt.lane[i].root = d.lane[i].root | (ROOT_W'(1) << bit_idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			q <= '0;
		else
			q <= nxt;
	end

endmodule

@@ hdl/triangle_face_normal_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle in Q1.14, one triangle per cycle.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  request   start / busy   vertices (tfn_req_t)
//  result    done strobe    normal   (tfn_rsp_t)
//
//  One request per cycle; busy is never raised.
//  Result strobes once the request has passed five front stages,
//  one chain cell per root bit (16) and the output register.
//  Reset clears all valid flags; no clearing pass.
//  The receiver cannot stall; nothing is held back.
module triangle_face_normal_unit import tfn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  tfn_req_t vertices,
	output logic     done,
	output tfn_rsp_t normal
);

	tfn_cell_t           chain [ROOT_W+1];
	tfn_cell_t           last;
	logic [ROOT_W:0]     rp [3];
	logic [OUT_W-1:0]    val [3];

	assign busy = 1'b0;

	tfn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.req    (vertices),
		.seed   (chain[0])
	);

	for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
		tfn_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bit_idx (IDX_W'(ROOT_W - 1 - g)),
			.d       (chain[g]),
			.q       (chain[g+1])
		);
	end

	assign last = chain[ROOT_W];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// round to nearest: largest odd t <= T gives q = (T + 1) / 2
			rp[i]  = {1'b0, last.lane[i].root} + 1'b1;
			val[i] = last.lane[i].neg ? OUT_W'(-rp[i][ROOT_W:1]) : OUT_W'(rp[i][ROOT_W:1]);
			if (last.deg)
				val[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		normal.normal_x   <= val[0];
		normal.normal_y   <= val[1];
		normal.normal_z   <= val[2];
		normal.degenerate <= last.deg;
	end

endmodule

@@ hdl/tfn_checker.sv @@
// ----------------------------------------------------------------------------
// tfn_checker
// Port level checks on the triangle face normal unit.
// ----------------------------------------------------------------------------
module tfn_port_checker import tfn_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input tfn_rsp_t normal
);

	localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << NORMAL_FRAC_BITS;

	// count only requests taken out of reset
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == ($past(start && !busy && arst_n, LATENCY) === 1'b1))
		else $error("result strobe does not follow request latency");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && normal.degenerate |->
			normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0)
		else $error("degenerate result with nonzero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> normal.normal_x <= ONE && normal.normal_x >= -ONE
			&& normal.normal_y <= ONE && normal.normal_y >= -ONE
			&& normal.normal_z <= ONE && normal.normal_z >= -ONE)
		else $error("normal component out of range");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !normal.degenerate |->
			normal.normal_x != '0 || normal.normal_y != '0 || normal.normal_z != '0)
		else $error("regular triangle gave zero normal");

endmodule

bind triangle_face_normal_unit tfn_port_checker u_tfn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.normal   (normal)
);
